>>> rtl/vas_pkg.sv
// Shared types and codes of the voice allocator.
package vas_pkg;

   // Event codes carried in the mode field
   localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
   localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
   localparam logic [1:0] MODE_RESET    = 2'd2;
   localparam logic [1:0] MODE_RETIRE   = 2'd3;

   // Voice life codes
   localparam logic [1:0] LIFE_FREE     = 2'd0;
   localparam logic [1:0] LIFE_ACTIVE   = 2'd1;
   localparam logic [1:0] LIFE_RELEASED = 2'd2;

   // Steal queue classes, in steal priority order
   localparam logic [2:0] CLS_QUIET_REL = 3'd0;
   localparam logic [2:0] CLS_QUIET_ACT = 3'd1;
   localparam logic [2:0] CLS_LOUD_REL  = 3'd2;
   localparam logic [2:0] CLS_LOUD_ACT  = 3'd3;
   localparam logic [2:0] CLS_NONE      = 3'd4;

   // Register indexes
   localparam logic CSR_QUIET_THR = 1'b0;
   localparam logic CSR_VOICES    = 1'b1;

   typedef struct packed {
      logic [1:0] mode;
      logic [3:0] channel;
      logic [6:0] note;
      logic [6:0] velocity;
      logic [5:0] target_voice;
   } req_data_type;

   typedef struct packed {
      logic        ok;
      logic [5:0]  voice_handle;
      logic        stolen;
      logic        quiet_steal;
      logic        release_steal;
      logic [6:0]  voices_released;
      logic [31:0] voice_number;
      logic [31:0] key_generation;
      logic [6:0]  active_count;
      logic [6:0]  released_count;
      logic [6:0]  peak_active;
   } rsp_data_type;

endpackage

>>> rtl/vas_rec_mem.sv
// Voice record memory with per-entry valid flags; an invalid entry reads with rd_valid low.
module vas_rec_mem #(
   parameter int DEPTH = 64,
   parameter int DW    = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        clr_all,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DW-1:0]                               rd_data,
   output logic                                        rd_valid,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DW-1:0]                               wr_data,
   input  logic                                        inv_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] inv_addr
);

   logic [DW-1:0]    mem_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [DW-1:0]    rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clr_all) begin
         vld_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= vld_ff[rd_addr];
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (inv_en) begin
            vld_ff[inv_addr] <= 1'b0;
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

>>> rtl/voice_allocator_with_stealing.sv
// Voice allocator: sequencer over voice record, key and free stack memories.
// A note-on takes a voice from the free stack, or steals the oldest queued voice when it is empty.
// A note-off walks the voices on the key list; a retire frees the named voice.
// A rejected word goes straight to the result; the next word is taken once the result is accepted.
// Reset (and the reset event) runs a clearing pass over every entry of the key
// memory; no word is taken meanwhile, configuration writes still land.
module voice_allocator_with_stealing #(
   parameter int MAX_VOICES = 64,
   parameter int CHANNELS   = 16,
   parameter int NOTES      = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  vas_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output vas_pkg::rsp_data_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [6:0]            csr_wdata
);

   import vas_pkg::*;

   // Handle width holds the NIL marker; counts share it
   localparam int HW    = $clog2(MAX_VOICES + 1);
   localparam int AW    = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int NKEYS = CHANNELS * NOTES;
   localparam int KW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
   localparam logic [HW-1:0] NIL        = HW'(MAX_VOICES);
   localparam logic [KW-1:0] NOTES_K    = KW'(NOTES);
   localparam logic [KW-1:0] LAST_KEY   = KW'(NKEYS - 1);
   localparam logic [HW-1:0] RESET_POOL = HW'((64 > MAX_VOICES) ? MAX_VOICES : 64);

   typedef struct packed {
      logic [1:0]    life;
      logic [2:0]    cls;
      logic [HW-1:0] qp;
      logic [HW-1:0] qn;
      logic [HW-1:0] kp;
      logic [HW-1:0] kn;
      logic [KW-1:0] key;
      logic [6:0]    vel;
   } rec_type;

   typedef struct packed {
      logic [HW-1:0] head;
      logic [31:0]   gen;
   } kent_type;

   typedef enum logic [1:0] {PF_QP, PF_QN, PF_KP, PF_KN} pfld_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_POP, S_POP_D, S_ST_RD, S_ST_D, S_DQ1, S_DQ2,
      S_DK1, S_DK2, S_DK2_D, S_DK3, S_RT_FIN, S_ON_KEY, S_ON_KEY_D, S_ON_WR,
      S_ON_P1, S_ON_P2, S_OFF_HEAD, S_OFF_HEAD_D, S_WALK_RD, S_WALK_D,
      S_REL_ENQ, S_REL_WR, S_REL_P, S_WALK_NEXT, S_PATCH_RD, S_PATCH_WR, S_RESULT
   } state_type;

   localparam rec_type RESET_REC = '{life: LIFE_FREE, cls: CLS_NONE, qp: NIL, qn: NIL,
                                     kp: NIL, kn: NIL, key: '0, vel: '0};

   // Configuration registers
   logic [6:0] thr_ff;
   logic [6:0] viu_ff;

   // Sequencer state
   state_type     state_ff;
   state_type     ret_ff;
   req_data_type  req_ff;
   rsp_data_type  out_ff;
   logic [KW-1:0] key_ff;
   logic [HW-1:0] h_ff;
   logic [HW-1:0] nx_ff;
   rec_type       cur_ff;
   logic [HW-1:0] pa_ff;
   logic [HW-1:0] pb_ff;
   logic [HW-1:0] pt_addr_ff;
   pfld_type      pt_fld_ff;
   logic [HW-1:0] pt_val_ff;
   logic [HW-1:0] head_ff [4];
   logic [HW-1:0] tail_ff [4];
   logic [HW-1:0] free_count_ff;
   logic [HW-1:0] pool_ff;
   logic [31:0]   nvn_ff;
   logic [HW-1:0] active_ff;
   logic [HW-1:0] released_ff;
   logic [HW-1:0] peak_ff;
   logic [HW-1:0] rel_n_ff;
   logic [KW-1:0] clr_idx_ff;
   logic          clr_rsp_ff;

   // Key memory: list head and note-on count per channel/note
   kent_type      key_mem_ff [NKEYS];
   kent_type      km_rdata_ff;
   logic [KW-1:0] km_raddr;
   logic          km_we;
   logic [KW-1:0] km_waddr;
   kent_type      km_wdata;

   // Free stack; entries never pushed read as the descending start order
   logic [HW-1:0]         free_mem_ff [MAX_VOICES];
   logic [MAX_VOICES-1:0] fvalid_ff;
   logic [HW-1:0]         fm_rdata_ff;
   logic                  fm_rvld_ff;
   logic [AW-1:0]         fm_idx_ff;
   logic                  fm_we;

   // Record memory port
   logic [AW-1:0] rec_rd_addr;
   logic [$bits(rec_type)-1:0] rec_rd_raw;
   logic          rec_rd_vld;
   rec_type       rd_rec;
   logic          rec_we;
   logic [AW-1:0] rec_waddr;
   rec_type       rec_wdata;
   rec_type       patched;
   logic          rec_inv;

   logic          rebuild;
   logic [HW-1:0] pool_in;
   logic [KW-1:0] key_in;
   logic          key_ok;
   logic          quiet;
   logic          quiet_rel;
   logic          any_q;
   logic [1:0]    q_sel;
   state_type     after_dq;
   state_type     after_dk;
   logic [2:0]    cls_act;
   logic [2:0]    cls_rel;
   logic [31:0]   gen_inc;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESULT);

   always_comb begin
      rsp_data                = out_ff;
      rsp_data.active_count   = 7'(active_ff);
      rsp_data.released_count = 7'(released_ff);
      rsp_data.peak_active    = 7'(peak_ff);
   end

   // Configuration writes land at any time
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
         viu_ff <= 7'd64;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_QUIET_THR: thr_ff <= csr_wdata;
            CSR_VOICES:    viu_ff <= csr_wdata;
            default:       thr_ff <= thr_ff;
         endcase
      end
   end

   // A reset event rebuilds like power-on reset, but sizes the pool from the voices register and gives a result
   assign rebuild = reset || (req_ready && req_valid && (viu_ff != '0)
                               && (req_data.mode == MODE_RESET));
   assign pool_in = reset ? RESET_POOL :
                    ((9'(viu_ff) > 9'(MAX_VOICES)) ? HW'(MAX_VOICES) : HW'(viu_ff));

   assign key_in = KW'(req_data.channel) * NOTES_K + KW'(req_data.note);
   assign key_ok = (5'(req_data.channel) < 5'(CHANNELS)) && (8'(req_data.note) < 8'(NOTES));
   assign quiet  = req_ff.velocity <= thr_ff;
   // A released voice is judged by the velocity stored with it
   assign quiet_rel = cur_ff.vel <= thr_ff;
   assign cls_act = quiet ? CLS_QUIET_ACT : CLS_LOUD_ACT;
   assign cls_rel = quiet_rel ? CLS_QUIET_REL : CLS_LOUD_REL;
   assign gen_inc = km_rdata_ff.gen + 32'd1;

   // Oldest victim: first nonempty queue in priority order
   always_comb begin
      any_q = 1'b0;
      q_sel = 2'd0;
      for (int i = 3; i >= 0; i--) begin
         if (head_ff[i] != NIL) begin
            any_q = 1'b1;
            q_sel = 2'(i);
         end
      end
   end

   assign after_dq = (req_ff.mode == MODE_NOTE_OFF) ? S_REL_ENQ : S_DK1;
   assign after_dk = (req_ff.mode == MODE_RETIRE) ? S_RT_FIN : S_ON_KEY;

   // Record memory control
   assign rd_rec = rec_rd_vld ? rec_type'(rec_rd_raw) : RESET_REC;

   always_comb begin
      patched = rd_rec;
      case (pt_fld_ff)
         PF_QP:   patched.qp = pt_val_ff;
         PF_QN:   patched.qn = pt_val_ff;
         PF_KP:   patched.kp = pt_val_ff;
         default: patched.kn = pt_val_ff;
      endcase
   end

   always_comb begin
      rec_rd_addr = h_ff[AW-1:0];
      rec_we      = 1'b0;
      rec_waddr   = h_ff[AW-1:0];
      rec_wdata   = cur_ff;
      rec_inv     = 1'b0;
      case (state_ff)
         S_PATCH_RD: rec_rd_addr = pt_addr_ff[AW-1:0];
         S_PATCH_WR: begin
            rec_we    = 1'b1;
            rec_waddr = pt_addr_ff[AW-1:0];
            rec_wdata = patched;
         end
         S_ON_WR, S_REL_WR: rec_we = 1'b1;
         S_RT_FIN: rec_inv = 1'b1;
         default: rec_we = 1'b0;
      endcase
   end

   vas_rec_mem #(
      .DEPTH (MAX_VOICES),
      .DW    ($bits(rec_type))
   ) u_rec_mem (
      .clock    (clock),
      .reset    (reset),
      .clr_all  (rebuild),
      .rd_addr  (rec_rd_addr),
      .rd_data  (rec_rd_raw),
      .rd_valid (rec_rd_vld),
      .wr_en    (rec_we),
      .wr_addr  (rec_waddr),
      .wr_data  (rec_wdata),
      .inv_en   (rec_inv),
      .inv_addr (h_ff[AW-1:0])
   );

   // Key memory control
   always_comb begin
      km_raddr = key_ff;
      km_we    = 1'b0;
      km_waddr = key_ff;
      km_wdata = '{head: h_ff, gen: gen_inc};
      case (state_ff)
         S_DK2: km_raddr = cur_ff.key;
         S_CLEAR: begin
            km_we    = 1'b1;
            km_waddr = clr_idx_ff;
            km_wdata = '{head: NIL, gen: '0};
         end
         S_DK2_D: begin
            // Drop the head pointer only when it still names this voice
            km_we    = (km_rdata_ff.head == h_ff);
            km_waddr = cur_ff.key;
            km_wdata = '{head: cur_ff.kn, gen: km_rdata_ff.gen};
         end
         S_ON_KEY_D: km_we = 1'b1;
         default: km_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (km_we) begin
         key_mem_ff[km_waddr] <= km_wdata;
      end
      km_rdata_ff <= key_mem_ff[km_raddr];
   end

   // Free stack: pop reads at the decremented count, retire pushes at the count
   assign fm_we = (state_ff == S_RT_FIN) && (free_count_ff < HW'(MAX_VOICES));

   always_ff @(posedge clock) begin
      if (fm_we) begin
         free_mem_ff[free_count_ff[AW-1:0]] <= h_ff;
      end
      fm_rdata_ff <= free_mem_ff[free_count_ff[AW-1:0]];
      fm_idx_ff   <= free_count_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (rebuild) begin
         fvalid_ff  <= '0;
         fm_rvld_ff <= 1'b0;
      end else begin
         fm_rvld_ff <= fvalid_ff[free_count_ff[AW-1:0]];
         if (fm_we) begin
            fvalid_ff[free_count_ff[AW-1:0]] <= 1'b1;
         end
      end
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (rebuild) begin
         state_ff      <= S_CLEAR;
         clr_rsp_ff    <= !reset;
         clr_idx_ff    <= '0;
         out_ff        <= '0;
         out_ff.ok     <= !reset;
         pool_ff       <= pool_in;
         free_count_ff <= pool_in;
         nvn_ff        <= 32'd1;
         active_ff     <= '0;
         released_ff   <= '0;
         peak_ff       <= '0;
         rel_n_ff      <= '0;
         ret_ff        <= S_IDLE;
         for (int i = 0; i < 4; i++) begin
            head_ff[i] <= NIL;
            tail_ff[i] <= NIL;
         end
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + KW'(1);
               if (clr_idx_ff == LAST_KEY) begin
                  state_ff <= clr_rsp_ff ? S_RESULT : S_IDLE;
               end
            end

            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  key_ff   <= key_in;
                  out_ff   <= '0;
                  rel_n_ff <= '0;
                  state_ff <= S_RESULT;
                  if (viu_ff != '0) begin
                     unique case (req_data.mode)
                        MODE_NOTE_ON: begin
                           if (key_ok) begin
                              if (free_count_ff != '0) begin
                                 free_count_ff <= free_count_ff - HW'(1);
                                 state_ff      <= S_POP;
                              end else if (any_q) begin
                                 // Steal the oldest voice of the best queue
                                 h_ff                 <= head_ff[q_sel];
                                 out_ff.stolen        <= 1'b1;
                                 out_ff.quiet_steal   <= !q_sel[1];
                                 out_ff.release_steal <= !q_sel[0];
                                 state_ff             <= S_ST_RD;
                              end
                           end
                        end
                        MODE_NOTE_OFF: begin
                           if (key_ok) begin
                              state_ff <= S_OFF_HEAD;
                           end
                        end
                        MODE_RETIRE: begin
                           if (10'(req_data.target_voice) < 10'(pool_ff)) begin
                              h_ff     <= HW'(req_data.target_voice);
                              state_ff <= S_ST_RD;
                           end
                        end
                        default: state_ff <= S_RESULT;
                     endcase
                  end
               end
            end

            S_POP: state_ff <= S_POP_D;

            S_POP_D: begin
               h_ff     <= fm_rvld_ff ? fm_rdata_ff
                                      : (pool_ff - HW'(1) - HW'(fm_idx_ff));
               state_ff <= S_ON_KEY;
            end

            S_ST_RD: state_ff <= S_ST_D;

            S_ST_D: begin
               cur_ff <= rd_rec;
               if (rd_rec.life == LIFE_FREE) begin
                  state_ff <= S_RESULT;
               end else begin
                  if (rd_rec.life == LIFE_ACTIVE) begin
                     active_ff <= active_ff - HW'(1);
                  end else begin
                     released_ff <= released_ff - HW'(1);
                  end
                  state_ff <= S_DQ1;
               end
            end

            // Unlink from the steal queue
            S_DQ1: begin
               if (cur_ff.qp != NIL) begin
                  pt_addr_ff <= cur_ff.qp;
                  pt_fld_ff  <= PF_QN;
                  pt_val_ff  <= cur_ff.qn;
                  ret_ff     <= S_DQ2;
                  state_ff   <= S_PATCH_RD;
               end else begin
                  head_ff[cur_ff.cls[1:0]] <= cur_ff.qn;
                  state_ff                 <= S_DQ2;
               end
            end

            S_DQ2: begin
               if (cur_ff.qn != NIL) begin
                  pt_addr_ff <= cur_ff.qn;
                  pt_fld_ff  <= PF_QP;
                  pt_val_ff  <= cur_ff.qp;
                  ret_ff     <= after_dq;
                  state_ff   <= S_PATCH_RD;
               end else begin
                  tail_ff[cur_ff.cls[1:0]] <= cur_ff.qp;
                  state_ff                 <= after_dq;
               end
            end

            // Unlink from the per-key list
            S_DK1: begin
               if (cur_ff.kp != NIL) begin
                  pt_addr_ff <= cur_ff.kp;
                  pt_fld_ff  <= PF_KN;
                  pt_val_ff  <= cur_ff.kn;
                  ret_ff     <= S_DK3;
                  state_ff   <= S_PATCH_RD;
               end else begin
                  state_ff <= S_DK2;
               end
            end

            S_DK2: state_ff <= S_DK2_D;

            S_DK2_D: state_ff <= S_DK3;

            S_DK3: begin
               if (cur_ff.kn != NIL) begin
                  pt_addr_ff <= cur_ff.kn;
                  pt_fld_ff  <= PF_KP;
                  pt_val_ff  <= cur_ff.kp;
                  ret_ff     <= after_dk;
                  state_ff   <= S_PATCH_RD;
               end else begin
                  state_ff <= after_dk;
               end
            end

            S_RT_FIN: begin
               if (free_count_ff < HW'(MAX_VOICES)) begin
                  free_count_ff <= free_count_ff + HW'(1);
               end
               out_ff.ok <= 1'b1;
               state_ff  <= S_RESULT;
            end

            S_ON_KEY: state_ff <= S_ON_KEY_D;

            // Claim the voice: bump generation, push on key list, append to queue
            S_ON_KEY_D: begin
               out_ff.ok             <= 1'b1;
               out_ff.voice_handle   <= 6'(h_ff);
               out_ff.voice_number   <= nvn_ff;
               out_ff.key_generation <= gen_inc;
               nvn_ff                <= nvn_ff + 32'd1;
               active_ff             <= active_ff + HW'(1);
               if ((active_ff + HW'(1)) > peak_ff) begin
                  peak_ff <= active_ff + HW'(1);
               end
               pa_ff <= km_rdata_ff.head;
               pb_ff <= tail_ff[cls_act[1:0]];
               cur_ff <= '{life: LIFE_ACTIVE, cls: cls_act, qp: tail_ff[cls_act[1:0]],
                           qn: NIL, kp: NIL, kn: km_rdata_ff.head, key: key_ff,
                           vel: req_ff.velocity};
               if (tail_ff[cls_act[1:0]] == NIL) begin
                  head_ff[cls_act[1:0]] <= h_ff;
               end
               tail_ff[cls_act[1:0]] <= h_ff;
               state_ff <= S_ON_WR;
            end

            S_ON_WR: state_ff <= S_ON_P1;

            S_ON_P1: begin
               if (pa_ff != NIL) begin
                  pt_addr_ff <= pa_ff;
                  pt_fld_ff  <= PF_KP;
                  pt_val_ff  <= h_ff;
                  ret_ff     <= S_ON_P2;
                  state_ff   <= S_PATCH_RD;
               end else begin
                  state_ff <= S_ON_P2;
               end
            end

            S_ON_P2: begin
               if (pb_ff != NIL) begin
                  pt_addr_ff <= pb_ff;
                  pt_fld_ff  <= PF_QN;
                  pt_val_ff  <= h_ff;
                  ret_ff     <= S_RESULT;
                  state_ff   <= S_PATCH_RD;
               end else begin
                  state_ff <= S_RESULT;
               end
            end

            S_OFF_HEAD: state_ff <= S_OFF_HEAD_D;

            S_OFF_HEAD_D: begin
               h_ff     <= km_rdata_ff.head;
               state_ff <= (km_rdata_ff.head == NIL) ? S_RESULT : S_WALK_RD;
            end

            // Walk the key list; release each active voice
            S_WALK_RD: state_ff <= S_WALK_D;

            S_WALK_D: begin
               cur_ff <= rd_rec;
               nx_ff  <= rd_rec.kn;
               if (rd_rec.life == LIFE_ACTIVE) begin
                  active_ff   <= active_ff - HW'(1);
                  released_ff <= released_ff + HW'(1);
                  rel_n_ff    <= rel_n_ff + HW'(1);
                  state_ff    <= S_DQ1;
               end else begin
                  state_ff <= S_WALK_NEXT;
               end
            end

            S_REL_ENQ: begin
               cur_ff.life <= LIFE_RELEASED;
               cur_ff.cls  <= cls_rel;
               cur_ff.qp   <= tail_ff[cls_rel[1:0]];
               cur_ff.qn   <= NIL;
               pb_ff       <= tail_ff[cls_rel[1:0]];
               if (tail_ff[cls_rel[1:0]] == NIL) begin
                  head_ff[cls_rel[1:0]] <= h_ff;
               end
               tail_ff[cls_rel[1:0]] <= h_ff;
               state_ff <= S_REL_WR;
            end

            S_REL_WR: state_ff <= S_REL_P;

            S_REL_P: begin
               if (pb_ff != NIL) begin
                  pt_addr_ff <= pb_ff;
                  pt_fld_ff  <= PF_QN;
                  pt_val_ff  <= h_ff;
                  ret_ff     <= S_WALK_NEXT;
                  state_ff   <= S_PATCH_RD;
               end else begin
                  state_ff <= S_WALK_NEXT;
               end
            end

            S_WALK_NEXT: begin
               if (nx_ff == NIL) begin
                  out_ff.ok              <= (rel_n_ff != '0);
                  out_ff.voices_released <= 7'(rel_n_ff);
                  state_ff               <= S_RESULT;
               end else begin
                  h_ff     <= nx_ff;
                  state_ff <= S_WALK_RD;
               end
            end

            // Shared read-modify-write of one link field in a neighbor record
            S_PATCH_RD: state_ff <= S_PATCH_WR;

            S_PATCH_WR: state_ff <= ret_ff;

            S_RESULT: begin
               if (rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
